// ===== sv/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared codes, defaults, the item type passed between the front and
// back parts of the sequencer and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

  // Default depth of the write byte store.
  localparam int MAX_BYTES_DEF = 16;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;
  localparam logic [7:0] UNIT_TICKS_RST  = 8'd1;
  localparam logic [9:0] ACK_TIMEOUT_RST = 10'd250;

  // Command codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    action_e     kind;
    logic        sda;
    logic [7:0]  data;
    logic [7:0]  addr;
    logic [4:0]  count;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       failed;
    logic       rejected;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/i2cmbs_req_if.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer item channel
// Valid/ready channel carrying one tick or command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       sda_in;
  logic [7:0] data_byte;
  logic [7:0] dev_addr;
  logic [4:0] read_count;

  modport source (output valid, action, sda_in, data_byte, dev_addr, read_count,
                  input ready);
  modport sink (input valid, action, sda_in, data_byte, dev_addr, read_count,
                output ready);
endinterface

`default_nettype wire

// ===== sv/i2cmbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer result channel
// Valid/ready channel carrying one result beat per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbs_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;
  logic       failed;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, rx_valid, rx_byte,
                  done_res, failed, rejected,
                  input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, rx_valid, rx_byte,
                done_res, failed, rejected,
                output ready);
endinterface

`default_nettype wire

// ===== sv/i2cmbs_front.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer front end
// Accepts item beats, classifies the action code and holds them in a
// two-entry queue in front of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  i2cmbs_req_if.sink             req,
  output i2cmbs_pkg::cmd_t       cmd_o,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i
);

  i2cmbs_pkg::cmd_t slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;
  i2cmbs_pkg::cmd_t cmd_new;

  assign req.ready   = (count_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    cmd_new.kind  = i2cmbs_pkg::action_e'(req.action);
    cmd_new.sda   = req.sda_in;
    cmd_new.data  = req.data_byte;
    cmd_new.addr  = req.dev_addr;
    cmd_new.count = req.read_count;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cmbs_back.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer back end
// Phase machine that drives SCL and SDA, holds the write byte store and
// registers one result beat per item taken from the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbs_back #(
  parameter int MAX_BYTES = i2cmbs_pkg::MAX_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       unit_ticks_i,
  input  wire logic [9:0]       ack_timeout_i,
  input  wire i2cmbs_pkg::cmd_t cmd_i,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  i2cmbs_rsp_if.source          rsp
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int BL_W  = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_SET, PH_TX_HIGH, PH_TX_LOW,
    PH_AK_REL, PH_AK_HIGH, PH_AK_POLL, PH_RX_LOW, PH_RX_HIGH,
    PH_RA_LOW, PH_RA_HIGH, PH_SP_A, PH_SP_B, PH_SP_C
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [9:0]        delay_q, delay_d;
  logic [2:0]        bitpos_q, bitpos_d;
  logic [7:0]        shift_q, shift_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [BL_W-1:0]   left_q, left_d;
  logic [BL_W-1:0]   left_dec;
  logic [IDX_W-1:0]  sidx_q, sidx_d;
  logic [9:0]        poll_q, poll_d;
  logic              is_read_q, is_read_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              stop_fail_q, stop_fail_d;

  logic [7:0]        store_mem [MAX_BYTES];
  logic [7:0]        rd_data_q;
  logic              store_we;

  i2cmbs_pkg::rsp_t  out_q, rsp_d;
  logic              out_valid_q;
  logic              step;

  logic [7:0]        unit;
  logic [9:0]        dly1, dly2, dly4;
  logic              expired, ack_ok;
  logic              go_tx, go_rx, go_stop, stop_fail_val;
  logic [7:0]        tx_byte;

  assign cmd_ready_o = !out_valid_q || rsp.ready;
  assign step        = cmd_valid_i && cmd_ready_o;

  // A zero unit count behaves as one tick per unit.
  assign unit = (unit_ticks_i == 8'd0) ? 8'd1 : unit_ticks_i;
  assign dly1 = {2'b00, unit};
  assign dly2 = {1'b0, unit, 1'b0};
  assign dly4 = {unit, 2'b00};

  always_comb begin
    phase_d       = phase_q;
    delay_d       = delay_q;
    bitpos_d      = bitpos_q;
    shift_d       = shift_q;
    fill_d        = fill_q;
    left_d        = left_q;
    sidx_d        = sidx_q;
    poll_d        = poll_q;
    is_read_d     = is_read_q;
    scl_d         = scl_q;
    sda_d         = sda_q;
    stop_fail_d   = stop_fail_q;
    store_we      = 1'b0;
    expired       = 1'b0;
    ack_ok        = 1'b0;
    go_tx         = 1'b0;
    go_rx         = 1'b0;
    go_stop       = 1'b0;
    stop_fail_val = 1'b0;
    tx_byte       = shift_q;
    left_dec      = left_q;
    rsp_d         = '0;

    if (step) begin
      if (cmd_i.kind != i2cmbs_pkg::ACT_TICK) begin
        if (phase_q != PH_IDLE) begin
          rsp_d.rejected = 1'b1;
        end else if (cmd_i.kind == i2cmbs_pkg::ACT_LOAD) begin
          if (fill_q < CNT_W'(MAX_BYTES)) begin
            store_we = 1'b1;
            fill_d   = fill_q + CNT_W'(1);
          end else begin
            rsp_d.rejected = 1'b1;
          end
        end else begin
          is_read_d = (cmd_i.kind == i2cmbs_pkg::ACT_READ);
          if (cmd_i.kind == i2cmbs_pkg::ACT_READ) begin
            shift_d = cmd_i.addr + 8'd1;
            left_d  = BL_W'(cmd_i.count);
          end else begin
            shift_d = cmd_i.addr;
            left_d  = BL_W'(fill_q);
            fill_d  = '0;
          end
          sidx_d      = '0;
          stop_fail_d = 1'b0;
          sda_d       = 1'b1;
          scl_d       = 1'b1;
          delay_d     = dly4;
          phase_d     = PH_ST_A;
        end
      end else if (phase_q == PH_AK_POLL) begin
        if (!cmd_i.sda) begin
          ack_ok = 1'b1;
        end else if (poll_q >= ack_timeout_i) begin
          go_stop       = 1'b1;
          stop_fail_val = 1'b1;
        end else begin
          poll_d = poll_q + 10'd1;
        end
      end else if (phase_q != PH_IDLE) begin
        if (delay_q > 10'd1) begin
          delay_d = delay_q - 10'd1;
        end else begin
          delay_d = '0;
          expired = 1'b1;
        end
      end

      // The slave acknowledged: move on to the next byte or to the stop.
      if (ack_ok) begin
        scl_d = 1'b0;
        if (left_q == '0) begin
          go_stop = 1'b1;
        end else if (is_read_q) begin
          go_rx = 1'b1;
        end else begin
          tx_byte = rd_data_q;
          sidx_d  = sidx_q + IDX_W'(1);
          left_d  = left_q - BL_W'(1);
          go_tx   = 1'b1;
        end
      end

      if (expired) begin
        unique case (phase_q)
          PH_ST_A: begin
            sda_d   = 1'b0;
            delay_d = dly4;
            phase_d = PH_ST_B;
          end
          PH_ST_B: begin
            go_tx = 1'b1;
          end
          PH_TX_SET: begin
            scl_d   = 1'b1;
            delay_d = dly2;
            phase_d = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            scl_d   = 1'b0;
            delay_d = dly2;
            phase_d = PH_TX_LOW;
          end
          PH_TX_LOW: begin
            if (bitpos_q != 3'd7) begin
              bitpos_d = bitpos_q + 3'd1;
              shift_d  = {shift_q[6:0], 1'b0};
              sda_d    = shift_q[6];
              delay_d  = dly2;
              phase_d  = PH_TX_SET;
            end else begin
              sda_d   = 1'b1;
              delay_d = dly1;
              phase_d = PH_AK_REL;
            end
          end
          PH_AK_REL: begin
            scl_d   = 1'b1;
            delay_d = dly1;
            phase_d = PH_AK_HIGH;
          end
          PH_AK_HIGH: begin
            poll_d  = '0;
            phase_d = PH_AK_POLL;
          end
          PH_RX_LOW: begin
            scl_d   = 1'b1;
            shift_d = {shift_q[6:0], cmd_i.sda};
            delay_d = dly1;
            phase_d = PH_RX_HIGH;
          end
          PH_RX_HIGH: begin
            scl_d = 1'b0;
            if (bitpos_q != 3'd7) begin
              bitpos_d = bitpos_q + 3'd1;
              delay_d  = dly2;
              phase_d  = PH_RX_LOW;
            end else begin
              rsp_d.rx_valid = 1'b1;
              rsp_d.rx_byte  = shift_q;
              if (left_q != '0) begin
                left_dec = left_q - BL_W'(1);
              end
              left_d  = left_dec;
              // Acknowledge every byte but the last one.
              sda_d   = (left_dec == '0);
              delay_d = dly2;
              phase_d = PH_RA_LOW;
            end
          end
          PH_RA_LOW: begin
            scl_d   = 1'b1;
            delay_d = dly2;
            phase_d = PH_RA_HIGH;
          end
          PH_RA_HIGH: begin
            scl_d = 1'b0;
            if (left_q != '0) begin
              go_rx = 1'b1;
            end else begin
              go_stop = 1'b1;
            end
          end
          PH_SP_A: begin
            scl_d   = 1'b1;
            delay_d = dly4;
            phase_d = PH_SP_B;
          end
          PH_SP_B: begin
            sda_d   = 1'b1;
            delay_d = dly4;
            phase_d = PH_SP_C;
          end
          PH_SP_C: begin
            rsp_d.done_res = 1'b1;
            rsp_d.failed   = stop_fail_q;
            stop_fail_d    = 1'b0;
            phase_d        = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      if (go_tx) begin
        shift_d  = tx_byte;
        bitpos_d = '0;
        scl_d    = 1'b0;
        sda_d    = tx_byte[7];
        delay_d  = dly2;
        phase_d  = PH_TX_SET;
      end
      if (go_rx) begin
        bitpos_d = '0;
        shift_d  = '0;
        scl_d    = 1'b0;
        sda_d    = 1'b1;
        delay_d  = dly2;
        phase_d  = PH_RX_LOW;
      end
      if (go_stop) begin
        stop_fail_d = stop_fail_val;
        scl_d       = 1'b0;
        sda_d       = 1'b0;
        delay_d     = dly4;
        phase_d     = PH_SP_A;
      end
    end

    rsp_d.scl_level = scl_d;
    rsp_d.sda_level = sda_d;
    rsp_d.busy_res  = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      delay_q     <= '0;
      bitpos_q    <= '0;
      shift_q     <= '0;
      fill_q      <= '0;
      left_q      <= '0;
      sidx_q      <= '0;
      poll_q      <= '0;
      is_read_q   <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      stop_fail_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      delay_q     <= delay_d;
      bitpos_q    <= bitpos_d;
      shift_q     <= shift_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      sidx_q      <= sidx_d;
      poll_q      <= poll_d;
      is_read_q   <= is_read_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      stop_fail_q <= stop_fail_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The store is read continuously at the current send index; that index
  // only moves many ticks before the byte is needed.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[fill_q[IDX_W-1:0]] <= cmd_i.data;
    end
    rd_data_q <= store_mem[sidx_q];
    if (step) begin
      out_q <= rsp_d;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.scl_level = out_q.scl_level;
  assign rsp.sda_level = out_q.sda_level;
  assign rsp.busy_res  = out_q.busy_res;
  assign rsp.rx_valid  = out_q.rx_valid;
  assign rsp.rx_byte   = out_q.rx_byte;
  assign rsp.done_res  = out_q.done_res;
  assign rsp.failed    = out_q.failed;
  assign rsp.rejected  = out_q.rejected;

endmodule

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Tick driven open-drain I2C master with a write byte store.
// ----------------------------------------------------------------------------
// Every accepted beat (a tick or a command) yields exactly one result beat.
// The block takes one beat per clock for as long as the result side keeps
// up: a two-entry queue sits in front of the phase machine and the result
// is held in an output register, so the sequencer handles one queued beat
// per clock; each beat passes through the queue and its result is registered.
// Bit timing counts ticks, not clocks: a delay unit lasts unit_ticks tick
// beats. No clearing pass follows reset; the byte store is read only at
// entries loaded since the last start of a write.
`default_nettype none

module i2c_master_bit_sequencer #(
  parameter int MAX_BYTES = i2cmbs_pkg::MAX_BYTES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [i2cmbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [i2cmbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  i2cmbs_req_if.sink                               req,
  i2cmbs_rsp_if.source                             rsp
);

  logic [7:0]       unit_ticks_q;
  logic [9:0]       ack_timeout_q;
  i2cmbs_pkg::cmd_t cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= i2cmbs_pkg::UNIT_TICKS_RST;
      ack_timeout_q <= i2cmbs_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cmbs_pkg::CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_wdata_i[7:0];
        i2cmbs_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  i2cmbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  i2cmbs_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_ticks_i  (unit_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .rsp           (rsp)
  );

endmodule

`default_nettype wire

// ===== bench/i2cmbs_seq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer result checker
// Watches the item and result channels and the register write port. It keeps
// its own copy of the phase machine, byte store and registers, works out the
// pin levels and flags each accepted item should give, and compares every
// result beat field by field with the oldest expectation still waiting.
// ----------------------------------------------------------------------------

module i2cmbs_seq_checker
  import i2cmbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  i2cmbs_req_if                      req_mon,
  i2cmbs_rsp_if                      rsp_mon,
  output int                         fail_count,
  output int                         outstanding
);

  localparam int STORE_DEPTH = MAX_BYTES_DEF;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_SET, PH_TX_HIGH, PH_TX_LOW,
    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
    PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } bus_phase_e;

  // Register copies.
  logic [7:0] unit_ticks;
  logic [9:0] ack_timeout;

  // Copy of the sequencer state.
  bus_phase_e phase;
  logic [9:0] delay_left;
  logic [2:0] bit_pos;
  logic [7:0] shift_byte;
  logic [4:0] fill_count;
  logic [4:0] bytes_left;
  logic [4:0] store_idx;
  logic [9:0] poll_count;
  logic       is_rd;
  logic       scl_drv;
  logic       sda_drv;
  logic       stop_fail;
  logic [7:0] byte_store [STORE_DEPTH];

  rsp_t expected_beats [$];
  rsp_t want_beat;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] seq_checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic load_delay(input int units);
    int u;
    u = (unit_ticks == 8'd0) ? 1 : int'(unit_ticks);
    delay_left = 10'(units * u);
  endtask

  task automatic start_tx(input logic [7:0] b);
    shift_byte = b;
    bit_pos    = '0;
    scl_drv    = 1'b0;
    sda_drv    = b[7];
    load_delay(2);
    phase      = PH_TX_SET;
  endtask

  task automatic start_rx();
    bit_pos    = '0;
    shift_byte = '0;
    scl_drv    = 1'b0;
    sda_drv    = 1'b1;
    load_delay(2);
    phase      = PH_RX_LOW;
  endtask

  task automatic start_stop(input logic fail);
    stop_fail = fail;
    scl_drv   = 1'b0;
    sda_drv   = 1'b0;
    load_delay(4);
    phase     = PH_STOP_A;
  endtask

  // Advances the bus copy by one item and queues the result it must give.
  task automatic predict_bus_step(input action_e act, input logic sda,
                                  input logic [7:0] data, input logic [7:0] addr,
                                  input logic [4:0] count);
    rsp_t res;
    logic expired;
    logic [7:0] next_byte;
    res     = '0;
    expired = 1'b0;

    if (act != ACT_TICK) begin
      if (phase != PH_IDLE) begin
        res.rejected = 1'b1;
      end else if (act == ACT_LOAD) begin
        if (fill_count < STORE_DEPTH) begin
          byte_store[fill_count[3:0]] = data;
          fill_count++;
        end else begin
          res.rejected = 1'b1;
        end
      end else begin
        is_rd = (act == ACT_READ);
        if (is_rd) begin
          shift_byte = addr + 8'd1;
          bytes_left = count;
        end else begin
          shift_byte = addr;
          bytes_left = fill_count;
          fill_count = '0;
        end
        store_idx = '0;
        stop_fail = 1'b0;
        sda_drv   = 1'b1;
        scl_drv   = 1'b1;
        load_delay(4);
        phase     = PH_START_A;
      end
    end else if (phase == PH_ACK_POLL) begin
      if (!sda) begin
        scl_drv = 1'b0;
        if (bytes_left == 5'd0) begin
          start_stop(1'b0);
        end else if (is_rd) begin
          start_rx();
        end else begin
          next_byte = (store_idx < STORE_DEPTH) ? byte_store[store_idx[3:0]] : 8'h00;
          store_idx++;
          bytes_left--;
          start_tx(next_byte);
        end
      end else if (poll_count >= ack_timeout) begin
        start_stop(1'b1);
      end else begin
        poll_count++;
      end
    end else if (phase != PH_IDLE) begin
      if (delay_left > 10'd1) begin
        delay_left--;
      end else begin
        delay_left = '0;
        expired    = 1'b1;
      end
    end

    if (expired) begin
      case (phase)
        PH_START_A: begin
          sda_drv = 1'b0;
          load_delay(4);
          phase = PH_START_B;
        end
        PH_START_B: start_tx(shift_byte);
        PH_TX_SET: begin
          scl_drv = 1'b1;
          load_delay(2);
          phase = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_drv = 1'b0;
          load_delay(2);
          phase = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          if (bit_pos < 3'd7) begin
            bit_pos++;
            shift_byte = shift_byte << 1;
            sda_drv = shift_byte[7];
            load_delay(2);
            phase = PH_TX_SET;
          end else begin
            sda_drv = 1'b1;
            load_delay(1);
            phase = PH_ACK_REL;
          end
        end
        PH_ACK_REL: begin
          scl_drv = 1'b1;
          load_delay(1);
          phase = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          poll_count = '0;
          phase = PH_ACK_POLL;
        end
        PH_RX_LOW: begin
          scl_drv = 1'b1;
          shift_byte = {shift_byte[6:0], sda};
          load_delay(1);
          phase = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          scl_drv = 1'b0;
          if (bit_pos < 3'd7) begin
            bit_pos++;
            load_delay(2);
            phase = PH_RX_LOW;
          end else begin
            res.rx_valid = 1'b1;
            res.rx_byte  = shift_byte;
            if (bytes_left > 5'd0) bytes_left--;
            // The master acknowledges every byte but the last one.
            sda_drv = (bytes_left != 5'd0) ? 1'b0 : 1'b1;
            load_delay(2);
            phase = PH_MACK_LOW;
          end
        end
        PH_MACK_LOW: begin
          scl_drv = 1'b1;
          load_delay(2);
          phase = PH_MACK_HIGH;
        end
        PH_MACK_HIGH: begin
          scl_drv = 1'b0;
          if (bytes_left > 5'd0) start_rx();
          else start_stop(1'b0);
        end
        PH_STOP_A: begin
          scl_drv = 1'b1;
          load_delay(4);
          phase = PH_STOP_B;
        end
        PH_STOP_B: begin
          sda_drv = 1'b1;
          load_delay(4);
          phase = PH_STOP_C;
        end
        PH_STOP_C: begin
          res.done_res = 1'b1;
          res.failed   = stop_fail;
          stop_fail    = 1'b0;
          phase        = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    end

    res.scl_level = scl_drv;
    res.sda_level = sda_drv;
    res.busy_res  = (phase != PH_IDLE);
    expected_beats.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks  = UNIT_TICKS_RST;
      ack_timeout = ACK_TIMEOUT_RST;
      phase       = PH_IDLE;
      delay_left  = '0;
      bit_pos     = '0;
      shift_byte  = '0;
      fill_count  = '0;
      bytes_left  = '0;
      store_idx   = '0;
      poll_count  = '0;
      is_rd       = 1'b0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      stop_fail   = 1'b0;
      foreach (byte_store[k]) byte_store[k] = '0;
      expected_beats.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with no item pending", 32'd0, 32'd0);
        end else begin
          want_beat = expected_beats.pop_front();
          if (rsp_mon.scl_level !== want_beat.scl_level)
            report_mismatch("scl_level", rsp_mon.scl_level, want_beat.scl_level);
          if (rsp_mon.sda_level !== want_beat.sda_level)
            report_mismatch("sda_level", rsp_mon.sda_level, want_beat.sda_level);
          if (rsp_mon.busy_res !== want_beat.busy_res)
            report_mismatch("busy_res", rsp_mon.busy_res, want_beat.busy_res);
          if (rsp_mon.rx_valid !== want_beat.rx_valid)
            report_mismatch("rx_valid", rsp_mon.rx_valid, want_beat.rx_valid);
          if (rsp_mon.rx_byte !== want_beat.rx_byte)
            report_mismatch("rx_byte", rsp_mon.rx_byte, want_beat.rx_byte);
          if (rsp_mon.done_res !== want_beat.done_res)
            report_mismatch("done_res", rsp_mon.done_res, want_beat.done_res);
          if (rsp_mon.failed !== want_beat.failed)
            report_mismatch("failed", rsp_mon.failed, want_beat.failed);
          if (rsp_mon.rejected !== want_beat.rejected)
            report_mismatch("rejected", rsp_mon.rejected, want_beat.rejected);
        end
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_UNIT_TICKS) unit_ticks = cfg_wdata_i[7:0];
        else if (cfg_idx_i == CFG_ACK_TIMEOUT) ack_timeout = cfg_wdata_i;
      end

      if (req_mon.valid && req_mon.ready) begin
        predict_bus_step(action_e'(req_mon.action), req_mon.sda_in, req_mon.data_byte,
                         req_mon.dev_addr, req_mon.read_count);
      end

      outstanding <= expected_beats.size();
    end
  end

endmodule

// ===== bench/tb_i2c_master_bit_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives tick and command beats into the sequencer with random gaps on both
// channels: a directed pass over edge values, rejections, timeouts and
// register changes, then phases of random transfers under several register
// settings. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_i2c_master_bit_sequencer;
  import i2cmbs_pkg::*;

  typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int        fail_count;
  int        outstanding;
  int        done_seen = 0;
  int        items_sent = 0;
  logic      idle_on = 1'b1;
  logic      squeeze_req = 1'b0;
  sda_mode_e sda_mode = SDA_RANDOM;

  i2cmbs_req_if req_ch ();
  i2cmbs_rsp_if rsp_ch ();

  i2c_master_bit_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  i2cmbs_seq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Transfers end when a result with done set has been taken.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready && rsp_ch.done_res) begin
      done_seen <= done_seen + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input action_e act, input logic sda, input logic [7:0] data,
                           input logic [7:0] addr, input logic [4:0] count);
    int gap;
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.sda_in     <= sda;
    req_ch.data_byte  <= data;
    req_ch.dev_addr   <= addr;
    req_ch.read_count <= count;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    logic s;
    case (sda_mode)
      SDA_LOW:  s = 1'b0;
      SDA_HIGH: s = 1'b1;
      default:  s = 1'($urandom_range(0, 1));
    endcase
    send_beat(ACT_TICK, s, 8'($urandom), 8'($urandom), 5'($urandom));
  endtask

  // Ticks until the running transfer reports done; now and then a command
  // slips in, which the block turns away while it is still busy.
  task automatic run_until_done();
    int target;
    target = done_seen + 1;
    while (done_seen < target) begin
      if ($urandom_range(0, 99) < 3) begin
        send_beat(action_e'($urandom_range(1, 3)), 1'($urandom), 8'($urandom),
                  8'($urandom), 5'($urandom));
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_transfer();
    int r;
    int n;
    logic [4:0] cnt;
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 99);
    sda_mode = (n < 85) ? SDA_RANDOM : (n < 95) ? SDA_LOW : SDA_HIGH;
    if (r < 40) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
      repeat (n) send_beat(ACT_LOAD, 1'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
      send_beat(ACT_WRITE, 1'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
      run_until_done();
    end else if (r < 78) begin
      cnt = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 3));
      send_beat(ACT_READ, 1'($urandom), 8'($urandom), 8'($urandom), cnt);
      run_until_done();
    end else begin
      // Stray beats while idle; a bare start here runs on under later ticks.
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(0, 9);
        if (n < 5) begin
          send_tick();
        end else if (n < 8) begin
          send_beat(ACT_LOAD, 1'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
        end else begin
          send_beat(action_e'($urandom_range(2, 3)), 1'($urandom), 8'($urandom),
                    8'($urandom), 5'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  task automatic run_random_phase(input logic [7:0] unit, input logic [9:0] ack_limit,
                                  input logic idle, input logic squeeze, input int budget);
    int base;
    settle();
    idle_on = idle;
    write_reg(CFG_UNIT_TICKS, 10'(unit));
    write_reg(CFG_ACK_TIMEOUT, ack_limit);
    squeeze_req = squeeze;
    base = items_sent;
    while (items_sent - base < budget) random_transfer();
  endtask

  // Result side: random ready with held stretches, plus one long hold-off.
  initial begin : result_sink
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        hold = 400;
      end else if (hold > 0) begin
        hold--;
      end else if (!idle_on) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        hold = pick_gap();
      end
      @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("i2c_master_bit_sequencer: mismatch");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_UNIT_TICKS;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_TICK;
    req_ch.sda_in     <= 1'b0;
    req_ch.data_byte  <= '0;
    req_ch.dev_addr   <= '0;
    req_ch.read_count <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks while idle do nothing.
    sda_mode = SDA_LOW;
    send_beat(ACT_TICK, 1'b0, 8'h00, 8'h00, 5'd0);
    send_beat(ACT_TICK, 1'b1, 8'hFF, 8'hFF, 5'd31);

    // A read of zero bytes; the address plus one wraps to zero.
    send_beat(ACT_READ, 1'b0, 8'h00, 8'hFF, 5'd0);
    run_until_done();

    // Write of three bytes, with every command kind refused while busy.
    send_beat(ACT_LOAD, 1'b0, 8'h00, 8'h00, 5'd0);
    send_beat(ACT_LOAD, 1'b1, 8'hFF, 8'hFF, 5'd0);
    send_beat(ACT_LOAD, 1'b0, 8'hA5, 8'h00, 5'd0);
    send_beat(ACT_WRITE, 1'b0, 8'h00, 8'h00, 5'd0);
    send_beat(ACT_LOAD, 1'b0, 8'h11, 8'h00, 5'd0);
    send_beat(ACT_WRITE, 1'b0, 8'h22, 8'h33, 5'd0);
    send_beat(ACT_READ, 1'b0, 8'h44, 8'h55, 5'd31);
    run_until_done();

    // The store was consumed, so this write sends the address alone.
    send_beat(ACT_WRITE, 1'b0, 8'h00, 8'h5A, 5'd0);
    run_until_done();

    sda_mode = SDA_RANDOM;
    send_beat(ACT_READ, 1'b0, 8'h00, 8'h80, 5'd2);
    run_until_done();

    // Seventeen loads: the last one finds the store full.
    sda_mode = SDA_LOW;
    repeat (17) send_beat(ACT_LOAD, 1'b0, 8'($urandom), 8'h00, 5'd0);
    send_beat(ACT_WRITE, 1'b0, 8'h00, 8'hC3, 5'd0);
    run_until_done();

    // Acknowledge timeouts at the longest and the shortest limit.
    settle();
    write_reg(CFG_ACK_TIMEOUT, 10'd1023);
    sda_mode = SDA_HIGH;
    send_beat(ACT_WRITE, 1'b0, 8'h00, 8'h7E, 5'd0);
    run_until_done();
    settle();
    write_reg(CFG_ACK_TIMEOUT, 10'd0);
    send_beat(ACT_READ, 1'b0, 8'h00, 8'h42, 5'd3);
    run_until_done();

    // A unit of zero counts as one; read the largest count the field holds.
    settle();
    write_reg(CFG_ACK_TIMEOUT, 10'd250);
    write_reg(CFG_UNIT_TICKS, 10'd0);
    sda_mode = SDA_RANDOM;
    send_beat(ACT_READ, 1'b0, 8'h00, 8'h01, 5'd31);
    run_until_done();

    // Unit changes in the middle of a transfer take effect at the next delay.
    settle();
    write_reg(CFG_UNIT_TICKS, 10'd1);
    sda_mode = SDA_LOW;
    send_beat(ACT_WRITE, 1'b0, 8'h00, 8'h55, 5'd0);
    repeat (30) send_tick();
    settle();
    write_reg(CFG_UNIT_TICKS, 10'd255);
    repeat (20) send_tick();
    settle();
    write_reg(CFG_UNIT_TICKS, 10'd2);
    run_until_done();

    run_random_phase(8'd1, 10'd250, 1'b1, 1'b1, 180);
    run_random_phase(8'd2, 10'd3, 1'b1, 1'b0, 180);
    run_random_phase(8'd1, 10'd1, 1'b0, 1'b0, 180);
    run_random_phase(8'd3, 10'd1023, 1'b1, 1'b0, 180);
    run_random_phase(8'd1, 10'd0, 1'b1, 1'b0, 180);
    run_random_phase(8'($urandom_range(1, 4)), 10'($urandom_range(1, 40)), 1'b1, 1'b0, 180);
    run_random_phase(8'd1, 10'd17, 1'b1, 1'b0, 180);

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("i2c_master_bit_sequencer: match");
    end else begin
      $display("i2c_master_bit_sequencer: mismatch");
    end
    $finish;
  end

endmodule
